// ----- hdl/olst_pkg.sv -----
`timescale 1ns / 1ps
package olst_pkg;

	localparam int DEPTH = 16;
	localparam int WIDTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 5;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] MODE_APPEND = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_ERASE  = 3'd2;
	localparam logic [2:0] MODE_REMOVE = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		logic               by_value;
		logic [WIDTH-1:0]   value;
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [4:0]  position;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic [4:0]  count;
	} rsp_t;

endpackage

// ----- hdl/olst_cell.sv -----
`timescale 1ns / 1ps
module olst_cell import olst_pkg::*; (
	input  logic             clk,
	input  cell_op_t         op,
	input  cell_cmd_t        cmd,
	input  logic             at_pos,
	input  logic             live,
	input  logic             after_in,
	output logic             after_out,
	input  logic [WIDTH-1:0] prev_data,
	input  logic [WIDTH-1:0] next_data,
	output logic [WIDTH-1:0] data
);

	logic [WIDTH-1:0] data_q;
	logic             hit;

	assign hit       = cmd.by_value ? (live && (data_q == cmd.value)) : at_pos;
	assign after_out = after_in | hit;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (at_pos) begin
					data_q <= cmd.value;
				end else if (after_in) begin
					data_q <= prev_data;
				end
			end
			CELL_SHIFT_DOWN: begin
				if (after_out) begin
					data_q <= next_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/ordered_list_shift_table_core.sv -----
`timescale 1ns / 1ps
// The response is registered on the accepting edge. Throughput: one request
// per cycle while rsp_ready is high; the row of cells shifts or compares
// every entry in parallel and the response register frees on the same edge.
// Reset: arst_n clears the entry count and the response valid flag at once;
// entry storage is not reset and is read only below the count.
module ordered_list_shift_table_core import olst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_nxt;
	logic             accept;
	cell_op_t         cell_op;
	cell_cmd_t        cmd;
	logic [CMP_W-1:0] eff_pos;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic             full;
	logic             found;
	logic [WIDTH-1:0] data   [DEPTH];
	logic [DEPTH:0]   after;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cnt_x = CMP_W'(count_q);
	assign pos_x = CMP_W'(req.position);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign found = after[DEPTH];

	assign cmd.by_value = (req.mode == MODE_REMOVE);
	assign cmd.value    = req.value[WIDTH-1:0];
	assign eff_pos      = (req.mode == MODE_APPEND) ? cnt_x : pos_x;

	always_comb begin
		cell_op            = CELL_HOLD;
		count_nxt          = count_q;
		rsp_nxt.read_value = '0;
		rsp_nxt.status     = ST_OK;
		case (req.mode)
			MODE_APPEND: begin
				if (full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					cell_op   = CELL_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_INSERT: begin
				if (pos_x > cnt_x) begin
					rsp_nxt.status = ST_RANGE;
				end else if (full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					cell_op   = CELL_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_ERASE: begin
				if (pos_x >= cnt_x) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					cell_op   = CELL_SHIFT_DOWN;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (found) begin
					cell_op   = CELL_SHIFT_DOWN;
					count_nxt = count_q - CNT_W'(1);
				end else begin
					rsp_nxt.status = ST_NOTFOUND;
				end
			end
			MODE_READ: begin
				if (pos_x >= cnt_x) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					rsp_nxt.read_value = 32'(data[req.position[IDX_W-1:0]]);
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			cell_op = CELL_HOLD;
		end
		rsp_nxt.count = 5'(count_nxt);
	end

	assign after[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] prev_d;
		logic [WIDTH-1:0] next_d;
		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid
			assign prev_d = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_body
			assign next_d = data[i+1];
		end
		olst_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.cmd       (cmd),
			.at_pos    (eff_pos == CMP_W'(i)),
			.live      (cnt_x > CMP_W'(i)),
			.after_in  (after[i]),
			.after_out (after[i+1]),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule
